/* rtl/ledfx_pkg.sv */
// ----------------------------------------------------------------------------
// ledfx_pkg
// Shared types, sizes and effect tables for the LED strip pixel generator.
// ----------------------------------------------------------------------------
package ledfx_pkg;

    localparam int MAX_PIXELS       = 1024;
    localparam int SIN_TABLE_BITS   = 8;
    localparam int GAUSS_TABLE_BITS = 8;

    localparam int PIX_AW     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int SIN_SIZE   = 1 << SIN_TABLE_BITS;
    localparam int GAUSS_SIZE = 1 << GAUSS_TABLE_BITS;

    // Configuration register indexes
    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_COLOR_A = 3'd1;
    localparam logic [2:0] REG_COLOR_B = 3'd2;
    localparam logic [2:0] REG_RATE    = 3'd3;
    localparam logic [2:0] REG_PWIDTH  = 3'd4;
    localparam logic [2:0] REG_INVW    = 3'd5;
    localparam logic [2:0] REG_PCOUNT  = 3'd6;
    localparam logic [2:0] REG_STRIP   = 3'd7;

    // Effect modes
    localparam logic [1:0] MODE_FADE   = 2'd0;
    localparam logic [1:0] MODE_PULSE  = 2'd1;
    localparam logic [1:0] MODE_SWFWD  = 2'd2;
    localparam logic [1:0] MODE_SWBACK = 2'd3;

    // Commands
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    typedef struct packed {
        logic        command;
        logic [9:0]  pixel_index;
        logic [23:0] pixel_rgb;
        logic [23:0] elapsed_time;
    } in_word_t;

    typedef struct packed {
        logic [9:0] out_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       done_res;
    } out_word_t;

    typedef struct packed {
        logic [1:0]  effect_mode;
        logic [23:0] color_a;
        logic [23:0] color_b;
        logic [15:0] step_rate;
        logic [15:0] packet_width;
        logic [15:0] inverse_width;
        logic [15:0] pulse_count;
        logic [10:0] strip_length;
    } cfg_t;

    // Word between the decode and shading halves of the pipeline
    typedef struct packed {
        logic [9:0]  idx;
        logic        swipe;
        logic [16:0] k;
        logic [23:0] c0;
        logic [23:0] c1;
        logic [40:0] dabs;
        logic        done;
    } mid_t;

    typedef logic [16:0] sin_tab_t   [SIN_SIZE];
    typedef logic [16:0] gauss_tab_t [GAUSS_SIZE];

    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned PI_Q30  = 64'd3373259426;

    typedef longint unsigned div6_t [6];
    typedef longint unsigned div8_t [8];
    localparam div6_t COS_DIV = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132};
    localparam div8_t EXP_DIV = '{64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd7, 64'd8};

    function automatic longint unsigned cos_series(input longint unsigned x);
        longint unsigned t;
        longint unsigned p;
        t = Q30_ONE;
        for (int k = 5; k >= 0; k--)
        begin
            p = ((x * t) >> 30) / COS_DIV[k];
            t = (p > Q30_ONE) ? 64'd0 : Q30_ONE - p;
        end
        return t;
    endfunction

    function automatic longint unsigned exp_series(input longint unsigned x);
        longint unsigned t;
        longint unsigned p;
        t = Q30_ONE;
        for (int k = 7; k >= 0; k--)
        begin
            p = ((x * t) >> 30) / EXP_DIV[k];
            t = (p > Q30_ONE) ? 64'd0 : Q30_ONE - p;
        end
        return t;
    endfunction

    // sin^2 of pi * i / SIN_SIZE, Q1.16
    function automatic sin_tab_t build_sin();
        sin_tab_t        tab;
        longint unsigned half;
        longint unsigned u;
        longint unsigned v;
        longint unsigned c;
        half = 64'd1 << (SIN_TABLE_BITS - 1);
        for (int i = 0; i < SIN_SIZE; i++)
        begin
            u = (longint'(i) >= half) ? longint'(i) - half : half - longint'(i);
            v = (PI_Q30 * (u << (30 - SIN_TABLE_BITS))) >> 30;
            c = cos_series((v * v) >> 30);
            tab[i] = 17'((c * c) >> 44);
        end
        return tab;
    endfunction

    // exp(-x^2) over x in [0,4), Q1.16
    function automatic gauss_tab_t build_gauss();
        gauss_tab_t      tab;
        longint unsigned x;
        longint unsigned y;
        longint unsigned e;
        for (int i = 0; i < GAUSS_SIZE; i++)
        begin
            x = longint'(i) << (32 - GAUSS_TABLE_BITS);
            y = (x * x) >> 30;
            e = exp_series(y >> 5);
            for (int k = 0; k < 5; k++)
            begin
                e = (e * e) >> 30;
            end
            tab[i] = 17'(e >> 14);
        end
        return tab;
    endfunction

    localparam sin_tab_t   SIN_TAB   = build_sin();
    localparam gauss_tab_t GAUSS_TAB = build_gauss();

endpackage

/* rtl/ledfx_cfg.sv */
// ----------------------------------------------------------------------------
// ledfx_cfg
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
module ledfx_cfg
    import ledfx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    // Decode the register index and capture the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.effect_mode   <= MODE_FADE;
            cfg_reg.color_a       <= '0;
            cfg_reg.color_b       <= '0;
            cfg_reg.step_rate     <= 16'd256;
            cfg_reg.packet_width  <= 16'd1024;
            cfg_reg.inverse_width <= 16'd16384;
            cfg_reg.pulse_count   <= 16'd256;
            cfg_reg.strip_length  <= 11'd1024;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:    cfg_reg.effect_mode   <= cfg_data[1:0];
                REG_COLOR_A: cfg_reg.color_a       <= cfg_data;
                REG_COLOR_B: cfg_reg.color_b       <= cfg_data;
                REG_RATE:    cfg_reg.step_rate     <= cfg_data[15:0];
                REG_PWIDTH:  cfg_reg.packet_width  <= cfg_data[15:0];
                REG_INVW:    cfg_reg.inverse_width <= cfg_data[15:0];
                REG_PCOUNT:  cfg_reg.pulse_count   <= cfg_data[15:0];
                REG_STRIP:   cfg_reg.strip_length  <= cfg_data[10:0];
                default:     cfg_reg.effect_mode   <= cfg_reg.effect_mode;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/ledfx_front.sv */
// ----------------------------------------------------------------------------
// ledfx_front
// Start color memory, progress multiply and per-effect decode (two stages).
// ----------------------------------------------------------------------------
module ledfx_front
    import ledfx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  in_word_t in_word,
    input  cfg_t     cfg,
    output logic     mid_valid,
    output mid_t     mid
);

    logic [23:0] mem [MAX_PIXELS];

    logic              accept;
    logic              in_range;
    logic [PIX_AW-1:0] addr;

    logic        v1_reg;
    logic [9:0]  idx1_reg;
    logic [39:0] p1_reg;
    logic [23:0] s1_reg;

    logic        v2_reg;
    mid_t        mid_reg;
    mid_t        mid_next;

    logic signed [42:0] ii;
    logic signed [42:0] w;
    logic signed [42:0] n;
    logic signed [42:0] tr;
    logic signed [42:0] diff;
    logic [42:0]        dmag;
    logic [23:0]        s_eff;

    assign accept   = in_valid && en;
    assign in_range = 32'(in_word.pixel_index) < MAX_PIXELS;
    assign addr     = PIX_AW'(in_word.pixel_index);

    // Store start colors on load words
    always_ff @(posedge clk)
    begin
        if (accept && (in_word.command == CMD_LOAD) && in_range)
        begin
            mem[addr] <= in_word.pixel_rgb;
        end
    end

    // Stage 1: read start color, form progress
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= in_range ? mem[addr] : 24'd0;
            idx1_reg <= in_word.pixel_index;
            p1_reg   <= 40'(in_word.elapsed_time) * 40'(cfg.step_rate);
        end
    end

    // Drop load words; only renders travel on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= accept && (in_word.command == CMD_RENDER);
            v2_reg <= v1_reg;
        end
    end

    // Stage 2: pick blend weight, colors and done per effect
    assign ii    = 43'(idx1_reg) <<< 24;
    assign w     = 43'(cfg.packet_width) <<< 16;
    assign n     = 43'(cfg.strip_length) <<< 24;
    assign tr    = 43'(p1_reg);
    assign diff  = (cfg.effect_mode == MODE_SWFWD) ? (ii + w - tr) : (ii - n - w + tr);
    assign dmag  = diff[42] ? 43'(-diff) : 43'(diff);
    assign s_eff = s1_reg;

    always_comb
    begin
        mid_next       = '0;
        mid_next.idx   = idx1_reg;
        mid_next.dabs  = dmag[40:0];
        unique case (cfg.effect_mode)
            MODE_FADE:
            begin
                mid_next.k    = (p1_reg >= 40'h1000000) ? 17'h10000 : 17'(p1_reg[23:8]);
                mid_next.c0   = s_eff;
                mid_next.c1   = cfg.color_a;
                mid_next.done = p1_reg > 40'h1000000;
            end
            MODE_PULSE:
            begin
                mid_next.k    = SIN_TAB[p1_reg[23:24-SIN_TABLE_BITS]];
                mid_next.c0   = cfg.color_a;
                mid_next.c1   = cfg.color_b;
                mid_next.done = p1_reg > (40'(cfg.pulse_count) << 16);
            end
            default:
            begin
                mid_next.swipe = 1'b1;
                mid_next.c0    = 24'd0;
                mid_next.c1    = cfg.color_a;
                mid_next.done  = tr >= (n + (w <<< 1));
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid_valid = v2_reg;
    assign mid       = mid_reg;

endmodule

/* rtl/ledfx_shade.sv */
// ----------------------------------------------------------------------------
// ledfx_shade
// Packet distance scaling with Gaussian lookup, then the channel blend.
// ----------------------------------------------------------------------------
module ledfx_shade
    import ledfx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      mid_valid,
    input  mid_t      mid,
    input  cfg_t      cfg,
    output logic      out_valid,
    output out_word_t out_word
);

    logic        v3_reg;
    mid_t        m3_reg;
    logic [56:0] prod3_reg;

    logic        v4_reg;
    out_word_t   out_reg;
    out_word_t   out_next;

    logic [16:0] k_eff;
    logic [16:0] k_inv;

    // Stage 3: scale distance by the inverse packet width
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m3_reg    <= mid;
            prod3_reg <= 57'(mid.dabs) * 57'(cfg.inverse_width);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= mid_valid;
            v4_reg <= v3_reg;
        end
    end

    // Stage 4: table lookup for swipe, then blend each channel
    always_comb
    begin
        if (!m3_reg.swipe)
        begin
            k_eff = m3_reg.k;
        end
        else if (prod3_reg[56:42] != '0)
        begin
            k_eff = 17'd0;
        end
        else
        begin
            k_eff = GAUSS_TAB[prod3_reg[41:42-GAUSS_TABLE_BITS]];
        end
    end

    assign k_inv = 17'h10000 - k_eff;

    always_comb
    begin
        logic [24:0] r;
        logic [24:0] g;
        logic [24:0] b;
        r = 25'(m3_reg.c0[23:16]) * 25'(k_inv) + 25'(m3_reg.c1[23:16]) * 25'(k_eff);
        g = 25'(m3_reg.c0[15:8])  * 25'(k_inv) + 25'(m3_reg.c1[15:8])  * 25'(k_eff);
        b = 25'(m3_reg.c0[7:0])   * 25'(k_inv) + 25'(m3_reg.c1[7:0])   * 25'(k_eff);
        out_next.out_index = m3_reg.idx;
        out_next.red       = r[23:16];
        out_next.green     = g[23:16];
        out_next.blue      = b[23:16];
        out_next.done_res  = m3_reg.done;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_word  = out_reg;

endmodule

/* rtl/led_strip_effect_pixel_generator.sv */
// ----------------------------------------------------------------------------
// led_strip_effect_pixel_generator
// Renders fade, pulse and swipe colors for LED strip pixels.
//
//   channel | direction | words
//   --------+-----------+----------------------------------------------
//   in      | in        | load (store start color) or render request
//   out     | out       | rendered pixel color and done flag
//   cfg     | in        | register writes, index 0..7
//
// A word is taken every cycle unless out is stalled; a render word reaches
// out through four register stages: progress multiply and color read,
// effect decode, distance multiply, table lookup and blend. A stalled out
// holds the whole pipeline. Reset clears the valid bits and sets the
// config registers to defaults; start colors are undefined until loaded.
// ----------------------------------------------------------------------------
module led_strip_effect_pixel_generator
    import ledfx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    cfg_t cfg;
    logic en;
    logic mid_valid;
    mid_t mid;

    // Advance unless the output word is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    ledfx_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ledfx_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_word   (in_word),
        .cfg       (cfg),
        .mid_valid (mid_valid),
        .mid       (mid)
    );

    ledfx_shade u_shade
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .mid_valid (mid_valid),
        .mid       (mid),
        .cfg       (cfg),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

endmodule
